### rtl/rar_pkg.sv
package rar_pkg;

    localparam int OPERAND_BITS_DEF = 16;
    localparam int RES_NUM_BITS     = 32;
    localparam int RES_DEN_BITS     = 31;
    // width used for the saturation compares, covers any magnitude up to 64 bits
    localparam int SAT_BITS         = 64;

    localparam logic [SAT_BITS-1:0] NUM_NEG_LIM = 64'h0000_0000_8000_0000;
    localparam logic [SAT_BITS-1:0] NUM_POS_LIM = 64'h0000_0000_7FFF_FFFF;
    localparam logic [SAT_BITS-1:0] DEN_LIM     = 64'h0000_0000_7FFF_FFFF;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_SUB = 2'd1;
    localparam logic [1:0] REQ_MUL = 2'd2;
    localparam logic [1:0] REQ_DIV = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_MAG,
        S_PAIR,
        S_XODD,
        S_GCD,
        S_DIV,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DOP_NONE,
        DOP_LOAD,
        DOP_MUL0,
        DOP_MUL1,
        DOP_MUL2,
        DOP_SUM,
        DOP_MAG,
        DOP_PAIR,
        DOP_XODD,
        DOP_GCD,
        DOP_DIV
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic num_zero;
        logic both_even;
        logic x_even;
        logic y_zero;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

### rtl/rar_ctrl.sv
module rar_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output rar_pkg::t_cmd  o_cmd,
    input  rar_pkg::t_stat i_stat
);

    rar_pkg::t_state r_state;
    rar_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rar_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rar_pkg::S_IDLE: begin
                if (i_valid) n_state = rar_pkg::S_MUL0;
            end
            rar_pkg::S_MUL0: n_state = rar_pkg::S_MUL1;
            rar_pkg::S_MUL1: n_state = rar_pkg::S_MUL2;
            rar_pkg::S_MUL2: n_state = rar_pkg::S_SUM;
            rar_pkg::S_SUM:  n_state = rar_pkg::S_MAG;
            rar_pkg::S_MAG: begin
                if (i_stat.err || i_stat.num_zero) n_state = rar_pkg::S_DONE;
                else                               n_state = rar_pkg::S_PAIR;
            end
            rar_pkg::S_PAIR: begin
                if (!i_stat.both_even) n_state = rar_pkg::S_XODD;
            end
            rar_pkg::S_XODD: begin
                if (!i_stat.x_even) n_state = rar_pkg::S_GCD;
            end
            rar_pkg::S_GCD: begin
                if (i_stat.y_zero) n_state = rar_pkg::S_DIV;
            end
            rar_pkg::S_DIV: begin
                if (i_stat.div_last) n_state = rar_pkg::S_DONE;
            end
            rar_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = rar_pkg::S_IDLE;
            end
            default: n_state = rar_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = 1'b0;
        o_cmd.op       = rar_pkg::DOP_NONE;
        o_cmd.out_load = 1'b0;
        case (r_state)
            rar_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) o_cmd.op = rar_pkg::DOP_LOAD;
            end
            rar_pkg::S_MUL0: o_cmd.op = rar_pkg::DOP_MUL0;
            rar_pkg::S_MUL1: o_cmd.op = rar_pkg::DOP_MUL1;
            rar_pkg::S_MUL2: o_cmd.op = rar_pkg::DOP_MUL2;
            rar_pkg::S_SUM:  o_cmd.op = rar_pkg::DOP_SUM;
            rar_pkg::S_MAG:  o_cmd.op = rar_pkg::DOP_MAG;
            rar_pkg::S_PAIR: begin
                if (i_stat.both_even) o_cmd.op = rar_pkg::DOP_PAIR;
            end
            rar_pkg::S_XODD: begin
                if (i_stat.x_even) o_cmd.op = rar_pkg::DOP_XODD;
            end
            rar_pkg::S_GCD:  o_cmd.op = rar_pkg::DOP_GCD;
            rar_pkg::S_DIV:  o_cmd.op = rar_pkg::DOP_DIV;
            rar_pkg::S_DONE: o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

### rtl/rar_dp.sv
module rar_dp #(
    parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  rar_pkg::t_cmd                           i_cmd,
    output rar_pkg::t_stat                          o_stat,
    input  logic [1:0]                              i_req_type,
    input  logic signed [OPERAND_BITS-1:0]          i_a_num,
    input  logic signed [OPERAND_BITS-1:0]          i_a_den,
    input  logic signed [OPERAND_BITS-1:0]          i_b_num,
    input  logic signed [OPERAND_BITS-1:0]          i_b_den,
    input  logic                                    i_ready,
    output logic                                    o_valid,
    output logic signed [rar_pkg::RES_NUM_BITS-1:0] o_res_num,
    output logic [rar_pkg::RES_DEN_BITS-1:0]        o_res_den,
    output logic                                    o_status
);

    localparam int W  = OPERAND_BITS;
    localparam int MW = 2 * W;
    localparam int CW = $clog2(MW);
    localparam int XW = rar_pkg::SAT_BITS;

    logic [1:0]             r_op;
    logic signed [W-1:0]    r_an, r_ad, r_bn, r_bd;
    logic                   r_err;
    logic signed [MW-1:0]   r_p0, r_p1, r_den;
    logic signed [MW:0]     r_num;
    logic                   r_neg, r_zero;
    logic [MW-1:0]          r_nm, r_dm, r_x, r_y, r_rn, r_rd;
    logic [CW-1:0]          r_cnt;
    logic                   r_out_valid;
    logic signed [rar_pkg::RES_NUM_BITS-1:0] r_out_num;
    logic [rar_pkg::RES_DEN_BITS-1:0]        r_out_den;
    logic                   r_out_st;

    // shared multiplier, operands picked by step
    logic signed [W-1:0]  m_a, m_b;
    logic signed [MW-1:0] w_prod;

    always_comb begin
        m_a = r_an;
        m_b = r_bd;
        case (i_cmd.op)
            rar_pkg::DOP_MUL0: begin
                m_a = r_an;
                m_b = (r_op == rar_pkg::REQ_MUL) ? r_bn : r_bd;
            end
            rar_pkg::DOP_MUL1: begin
                m_a = r_bn;
                m_b = r_ad;
            end
            rar_pkg::DOP_MUL2: begin
                m_a = r_ad;
                m_b = (r_op == rar_pkg::REQ_DIV) ? r_bn : r_bd;
            end
            default: ;
        endcase
    end

    assign w_prod = m_a * m_b;

    logic signed [MW:0] w_sum;
    always_comb begin
        case (r_op)
            rar_pkg::REQ_ADD: w_sum = (MW+1)'(r_p0) + (MW+1)'(r_p1);
            rar_pkg::REQ_SUB: w_sum = (MW+1)'(r_p0) - (MW+1)'(r_p1);
            default:          w_sum = (MW+1)'(r_p0);
        endcase
    end

    // magnitudes; |num| <= 2^(MW-1), |den| <= 2^(MW-2)
    logic signed [MW:0]   w_nabs;
    logic signed [MW-1:0] w_dabs;
    assign w_nabs = r_num[MW] ? -r_num : r_num;
    assign w_dabs = r_den[MW-1] ? -r_den : r_den;

    logic          w_xgt;
    logic [MW-1:0] w_diff;
    assign w_xgt  = r_x > r_y;
    assign w_diff = w_xgt ? (r_x - r_y) : (r_y - r_x);

    // restoring divide of both magnitudes by the odd part of the gcd
    logic [MW:0] w_sn, w_sd, w_tn, w_td;
    assign w_sn = {r_rn, r_nm[MW-1]};
    assign w_sd = {r_rd, r_dm[MW-1]};
    assign w_tn = w_sn - {1'b0, r_x};
    assign w_td = w_sd - {1'b0, r_x};

    // output packing with saturation
    logic [XW-1:0] w_nx, w_dx, w_nsat, w_nneg;
    logic signed [rar_pkg::RES_NUM_BITS-1:0] w_res_num;
    logic [rar_pkg::RES_DEN_BITS-1:0]        w_res_den;
    logic                                    w_res_st;

    assign w_nx = {{(XW-MW){1'b0}}, r_nm};
    assign w_dx = {{(XW-MW){1'b0}}, r_dm};

    always_comb begin
        if (r_neg) w_nsat = (w_nx > rar_pkg::NUM_NEG_LIM) ? rar_pkg::NUM_NEG_LIM : w_nx;
        else       w_nsat = (w_nx > rar_pkg::NUM_POS_LIM) ? rar_pkg::NUM_POS_LIM : w_nx;
        w_nneg = {XW{1'b0}} - w_nsat;
        if (r_err) begin
            w_res_num = '0;
            w_res_den = '0;
            w_res_st  = 1'b1;
        end else if (r_zero) begin
            w_res_num = '0;
            w_res_den = rar_pkg::RES_DEN_BITS'(1);
            w_res_st  = 1'b0;
        end else begin
            w_res_num = r_neg ? w_nneg[rar_pkg::RES_NUM_BITS-1:0]
                              : w_nsat[rar_pkg::RES_NUM_BITS-1:0];
            w_res_den = (w_dx > rar_pkg::DEN_LIM) ? rar_pkg::DEN_LIM[rar_pkg::RES_DEN_BITS-1:0]
                                                  : w_dx[rar_pkg::RES_DEN_BITS-1:0];
            w_res_st  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rar_pkg::DOP_LOAD: begin
                r_op  <= i_req_type;
                r_an  <= i_a_num;
                r_ad  <= i_a_den;
                r_bn  <= i_b_num;
                r_bd  <= i_b_den;
                r_err <= (i_a_den == '0) || (i_b_den == '0) ||
                         ((i_req_type == rar_pkg::REQ_DIV) && (i_b_num == '0));
            end
            rar_pkg::DOP_MUL0: r_p0  <= w_prod;
            rar_pkg::DOP_MUL1: r_p1  <= w_prod;
            rar_pkg::DOP_MUL2: r_den <= w_prod;
            rar_pkg::DOP_SUM:  r_num <= w_sum;
            rar_pkg::DOP_MAG: begin
                r_neg  <= r_num[MW] ^ r_den[MW-1];
                r_zero <= (r_num == '0);
                r_nm   <= w_nabs[MW-1:0];
                r_dm   <= w_dabs;
                r_x    <= w_nabs[MW-1:0];
                r_y    <= w_dabs;
            end
            rar_pkg::DOP_PAIR: begin
                // common power of two comes off everything
                r_x  <= r_x >> 1;
                r_y  <= r_y >> 1;
                r_nm <= r_nm >> 1;
                r_dm <= r_dm >> 1;
            end
            rar_pkg::DOP_XODD: r_x <= r_x >> 1;
            rar_pkg::DOP_GCD: begin
                if (r_y == '0) begin
                    r_rn  <= '0;
                    r_rd  <= '0;
                    r_cnt <= '0;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else begin
                    if (w_xgt) r_x <= r_y;
                    r_y <= w_diff;
                end
            end
            rar_pkg::DOP_DIV: begin
                r_cnt <= r_cnt + CW'(1);
                if (!w_tn[MW]) begin
                    r_rn <= w_tn[MW-1:0];
                    r_nm <= {r_nm[MW-2:0], 1'b1};
                end else begin
                    r_rn <= w_sn[MW-1:0];
                    r_nm <= {r_nm[MW-2:0], 1'b0};
                end
                if (!w_td[MW]) begin
                    r_rd <= w_td[MW-1:0];
                    r_dm <= {r_dm[MW-2:0], 1'b1};
                end else begin
                    r_rd <= w_sd[MW-1:0];
                    r_dm <= {r_dm[MW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_num <= w_res_num;
            r_out_den <= w_res_den;
            r_out_st  <= w_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.err       = r_err;
    assign o_stat.num_zero  = (r_num == '0);
    assign o_stat.both_even = !(r_x[0] || r_y[0]);
    assign o_stat.x_even    = !r_x[0];
    assign o_stat.y_zero    = (r_y == '0);
    assign o_stat.div_last  = (r_cnt == CW'(MW - 1));
    assign o_stat.out_free  = !r_out_valid || i_ready;

    assign o_valid   = r_out_valid;
    assign o_res_num = r_out_num;
    assign o_res_den = r_out_den;
    assign o_status  = r_out_st;

endmodule

### rtl/rational_arith_reduce.sv
// Run time grows with P = common factors of two, Z = further halvings of the numerator,
//   G = gcd steps, and with the operand width through the bit-serial divide; an error or
//   a zero numerator skips the gcd and the divide.
// Throughput: one request in flight; the gcd loop and the bit-serial divider set the rate.
//   The next request is taken as soon as a result sits in the output register.
// Reset: synchronous, active low; clears the controller and the output valid flag.
module rational_arith_reduce #(
    parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [1:0]                              i_req_type,
    input  logic signed [OPERAND_BITS-1:0]          i_a_num,
    input  logic signed [OPERAND_BITS-1:0]          i_a_den,
    input  logic signed [OPERAND_BITS-1:0]          i_b_num,
    input  logic signed [OPERAND_BITS-1:0]          i_b_den,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [rar_pkg::RES_NUM_BITS-1:0] o_res_num,
    output logic [rar_pkg::RES_DEN_BITS-1:0]        o_res_den,
    output logic                                    o_status
);

    // Flow of one request:
    //   load operands and flag a zero denominator / zero divisor up front,
    //   three passes through one signed multiplier (two numerator terms, one
    //   denominator), add or subtract the numerator terms (mul and div keep the
    //   first term), take magnitudes and the result sign, then binary gcd on the
    //   magnitudes. Shared powers of two are stripped from the dividends alongside,
    //   so the closing divide is by the odd gcd part only; one restoring divider per
    //   magnitude, one bit a cycle. Packing saturates to the 32/31-bit result fields
    //   (only reachable at wide operand settings).

    rar_pkg::t_cmd  w_cmd;
    rar_pkg::t_stat w_stat;

    rar_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    rar_dp #(
        .OPERAND_BITS (OPERAND_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_req_type (i_req_type),
        .i_a_num    (i_a_num),
        .i_a_den    (i_a_den),
        .i_b_num    (i_b_num),
        .i_b_den    (i_b_den),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_res_num  (o_res_num),
        .o_res_den  (o_res_den),
        .o_status   (o_status)
    );

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("result loaded over a pending one");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second request taken while busy");

    // error results carry zero fields
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_res_num == '0) && (o_res_den == '0))
        else $error("error result with nonzero fields");

    // good results have a positive denominator
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_status) |-> (o_res_den != '0))
        else $error("zero denominator on good result");

endmodule
